/* rtl/core/binary_min_heap_queue_unit_macros.svh */
// assertion helpers for the heap queue
`ifndef BINARY_MIN_HEAP_QUEUE_UNIT_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BMHQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BMHQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bmhq_pkg.sv */
package bmhq_pkg;

  localparam int DEF_CAPACITY = 256;
  localparam int ID_W         = 8;
  localparam int KEY_W        = 31;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 9;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef logic [3:0] cmd_t;

  localparam cmd_t CMD_NONE      = 4'd0;
  localparam cmd_t CMD_LOAD      = 4'd1;
  localparam cmd_t CMD_ERR_FULL  = 4'd2;
  localparam cmd_t CMD_ERR_EMPTY = 4'd3;
  localparam cmd_t CMD_PUSH_INIT = 4'd4;
  localparam cmd_t CMD_POP_INIT  = 4'd5;
  localparam cmd_t CMD_RD_PARENT = 4'd6;
  localparam cmd_t CMD_UP_MOVE   = 4'd7;
  localparam cmd_t CMD_WRITE_MOV = 4'd8;
  localparam cmd_t CMD_POP_CAP   = 4'd9;
  localparam cmd_t CMD_RD_KIDS   = 4'd10;
  localparam cmd_t CMD_DN_MOVE_L = 4'd11;
  localparam cmd_t CMD_DN_MOVE_R = 4'd12;
  localparam cmd_t CMD_FINISH    = 4'd13;

  typedef logic [1:0] dn_t;

  localparam dn_t DN_STOP  = 2'd0;
  localparam dn_t DN_LEFT  = 2'd1;
  localparam dn_t DN_RIGHT = 2'd2;

  typedef struct packed {
    logic mode_pop;
    logic full;
    logic empty;
    logic pos_zero;
    logic up_less;
    logic left_in;
    dn_t  dn_dir;
    logic out_free;
  } stat_t;

endpackage

/* rtl/core/bmhq_in_if.sv */
interface bmhq_in_if import bmhq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [ID_W-1:0]  item_id;
  logic [KEY_W-1:0] item_key;

  modport source (output valid, mode, item_id, item_key, input ready);
  modport sink (input valid, mode, item_id, item_key, output ready);
endinterface

/* rtl/core/bmhq_out_if.sv */
interface bmhq_out_if import bmhq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     popped_id;
  logic [KEY_W-1:0]    popped_key;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, popped_id, popped_key, status, entry_count, input ready);
  modport sink (input valid, popped_id, popped_key, status, entry_count, output ready);
endinterface

/* rtl/core/binary_min_heap_queue_unit.sv */
// Min-heap priority queue of 8-bit ids ordered by 31-bit keys, held in one
// CAPACITY-entry memory with one write and two registered read ports. Each
// request is a push (mode 0) or a pop of the smallest key (mode 1) and gives
// exactly one result with the popped entry, a status (ok, pop on empty,
// push on full) and the entry count afterwards. Requests are handled one
// at a time; a result may wait in the output register while the next
// request is taken. A push takes a slot at the end of the heap and then
// climbs: each level reads the parent, then compares and moves the parent
// down, until the entry is written at the root or below a parent not larger.
// A pop fetches the root and the last entry together, captures them, and
// sinks the last entry from the root: each level reads both children, then
// compares and moves the smaller child up, until the entry is written. When
// the pop takes the only entry it finishes without sinking; refused requests
// go straight to the result. A result still waiting in the output register
// holds the block in its finish state until it is taken, so the next request
// waits. Among equal keys a pushed entry stays below its parent, a sinking
// entry stays above its children, and between equal children it goes right.
`include "binary_min_heap_queue_unit_macros.svh"

module binary_min_heap_queue_unit import bmhq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input logic       clk,
  input logic       rst_n,
  bmhq_in_if.sink   in_ch,
  bmhq_out_if.source out_ch
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign in_ch.ready = in_ready;

  bmhq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmhq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_mode         (in_ch.mode),
    .in_item_id      (in_ch.item_id),
    .in_item_key     (in_ch.item_key),
    .out_ready       (out_ch.ready),
    .stat            (stat),
    .out_valid       (out_ch.valid),
    .out_popped_id   (out_ch.popped_id),
    .out_popped_key  (out_ch.popped_key),
    .out_status      (out_ch.status),
    .out_entry_count (out_ch.entry_count)
  );

  `BMHQ_ASSERT_NEXT(a_one_at_a_time, in_ch.valid && in_ready, !in_ready, "request taken while busy")
  `BMHQ_ASSERT_NOW(a_empty_count, out_ch.valid && out_ch.status == ST_EMPTY, out_ch.entry_count == '0, "empty pop with nonzero count")
  `BMHQ_ASSERT_NOW(a_err_payload, out_ch.valid && out_ch.status != ST_OK, out_ch.popped_id == '0 && out_ch.popped_key == '0, "refused request carries payload")
  `BMHQ_ASSERT_NOW(a_count_flags, 1'b1, !(stat.full && stat.empty), "heap both full and empty")

endmodule

/* rtl/core/bmhq_dp.sv */
module bmhq_dp import bmhq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  input  logic                in_mode,
  input  logic [ID_W-1:0]     in_item_id,
  input  logic [KEY_W-1:0]    in_item_key,
  input  logic                out_ready,
  output stat_t               stat,
  output logic                out_valid,
  output logic [ID_W-1:0]     out_popped_id,
  output logic [KEY_W-1:0]    out_popped_key,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + 1;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  entry_t mem [CAPACITY];

  entry_t              rd_a_r, rd_b_r;
  entry_t              mov_r, mov_nxt;
  entry_t              res_r, res_nxt;
  logic                mode_r, mode_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [STATUS_W-1:0] sts_r, sts_nxt;
  logic                out_valid_r, out_valid_nxt;
  entry_t              out_ent_r, out_ent_nxt;
  logic [STATUS_W-1:0] out_sts_r, out_sts_nxt;
  logic [CW-1:0]       out_cnt_r, out_cnt_nxt;

  logic [AW-1:0] parent_a, left_a, right_a, last_a;
  logic [XW-1:0] left_x, right_x, cnt_x;
  logic          left_in, right_in;
  logic          rd_a_en, rd_b_en, wr_en;
  logic [AW-1:0] rd_a_addr, rd_b_addr;
  entry_t        wr_data;
  dn_t           dn_dir;

  // child and parent indexes of the hole
  assign parent_a = AW'((pos_r - AW'(1)) >> 1);
  assign left_x   = XW'({pos_r, 1'b1});
  assign right_x  = left_x + XW'(1);
  assign cnt_x    = XW'(cnt_r);
  assign left_in  = left_x < cnt_x;
  assign right_in = right_x < cnt_x;
  assign left_a   = left_x[AW-1:0];
  // keep the right read in range when there is no right child
  assign right_a  = right_in ? right_x[AW-1:0] : left_a;
  assign last_a   = AW'(cnt_r - CW'(1));

  always_comb begin
    dn_dir = DN_STOP;
    if (right_in) begin
      if (mov_r.key <= rd_a_r.key && mov_r.key <= rd_b_r.key) begin
        dn_dir = DN_STOP;
      end else if (rd_a_r.key < rd_b_r.key) begin
        dn_dir = DN_LEFT;
      end else begin
        dn_dir = DN_RIGHT;
      end
    end else if (rd_a_r.key < mov_r.key) begin
      dn_dir = DN_LEFT;
    end
  end

  always_comb begin
    rd_a_en   = 1'b0;
    rd_b_en   = 1'b0;
    rd_a_addr = parent_a;
    rd_b_addr = right_a;
    wr_en     = 1'b0;
    wr_data   = mov_r;
    case (cmd)
      CMD_RD_PARENT: begin
        rd_a_en = 1'b1;
      end
      CMD_POP_INIT: begin
        rd_a_en   = 1'b1;
        rd_b_en   = 1'b1;
        rd_a_addr = '0;
        rd_b_addr = last_a;
      end
      CMD_RD_KIDS: begin
        rd_a_en   = 1'b1;
        rd_b_en   = 1'b1;
        rd_a_addr = left_a;
      end
      CMD_WRITE_MOV: begin
        wr_en = 1'b1;
      end
      CMD_UP_MOVE, CMD_DN_MOVE_L: begin
        wr_en   = 1'b1;
        wr_data = rd_a_r;
      end
      CMD_DN_MOVE_R: begin
        wr_en   = 1'b1;
        wr_data = rd_b_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos_r] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_r <= mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_r <= mem[rd_b_addr];
    end
  end

  always_comb begin
    mov_nxt       = mov_r;
    res_nxt       = res_r;
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    sts_nxt       = sts_r;
    out_ent_nxt   = out_ent_r;
    out_sts_nxt   = out_sts_r;
    out_cnt_nxt   = out_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (cmd)
      CMD_LOAD: begin
        mode_nxt = in_mode;
        mov_nxt  = '{id: in_item_id, key: in_item_key};
        res_nxt  = '0;
        sts_nxt  = ST_OK;
      end
      CMD_ERR_FULL:  sts_nxt = ST_FULL;
      CMD_ERR_EMPTY: sts_nxt = ST_EMPTY;
      CMD_PUSH_INIT: begin
        pos_nxt = AW'(cnt_r);
        cnt_nxt = cnt_r + CW'(1);
      end
      CMD_POP_INIT:  cnt_nxt = cnt_r - CW'(1);
      CMD_UP_MOVE:   pos_nxt = parent_a;
      CMD_POP_CAP: begin
        res_nxt = rd_a_r;
        mov_nxt = rd_b_r;
        pos_nxt = '0;
      end
      CMD_DN_MOVE_L: pos_nxt = left_a;
      CMD_DN_MOVE_R: pos_nxt = right_x[AW-1:0];
      CMD_FINISH: begin
        out_valid_nxt = 1'b1;
        out_ent_nxt   = res_r;
        out_sts_nxt   = sts_r;
        out_cnt_nxt   = cnt_r;
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mov_r     <= mov_nxt;
    res_r     <= res_nxt;
    mode_r    <= mode_nxt;
    pos_r     <= pos_nxt;
    sts_r     <= sts_nxt;
    out_ent_r <= out_ent_nxt;
    out_sts_r <= out_sts_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  always_comb begin
    stat.mode_pop = mode_r;
    stat.full     = cnt_r == CAP_CNT;
    stat.empty    = cnt_r == '0;
    stat.pos_zero = pos_r == '0;
    stat.up_less  = mov_r.key < rd_a_r.key;
    stat.left_in  = left_in;
    stat.dn_dir   = dn_dir;
    stat.out_free = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_popped_id   = out_ent_r.id;
  assign out_popped_key  = out_ent_r.key;
  assign out_status      = out_sts_r;
  assign out_entry_count = COUNT_W'(out_cnt_r);

endmodule

/* rtl/core/bmhq_ctrl.sv */
module bmhq_ctrl import bmhq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECIDE  = 3'd1;
  localparam logic [2:0] S_UP_CHK  = 3'd2;
  localparam logic [2:0] S_UP_CMP  = 3'd3;
  localparam logic [2:0] S_POP_CAP = 3'd4;
  localparam logic [2:0] S_DN_CHK  = 3'd5;
  localparam logic [2:0] S_DN_CMP  = 3'd6;
  localparam logic [2:0] S_FINISH  = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.mode_pop == MODE_POP) begin
          if (stat.empty) begin
            cmd       = CMD_ERR_EMPTY;
            state_nxt = S_FINISH;
          end else begin
            // fetch root and last entry together
            cmd       = CMD_POP_INIT;
            state_nxt = S_POP_CAP;
          end
        end else if (stat.full) begin
          cmd       = CMD_ERR_FULL;
          state_nxt = S_FINISH;
        end else begin
          cmd       = CMD_PUSH_INIT;
          state_nxt = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        if (stat.pos_zero) begin
          cmd       = CMD_WRITE_MOV;
          state_nxt = S_FINISH;
        end else begin
          cmd       = CMD_RD_PARENT;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_less) begin
          cmd       = CMD_UP_MOVE;
          state_nxt = S_UP_CHK;
        end else begin
          cmd       = CMD_WRITE_MOV;
          state_nxt = S_FINISH;
        end
      end
      S_POP_CAP: begin
        cmd       = CMD_POP_CAP;
        // heap now empty: nothing to sift
        state_nxt = stat.empty ? S_FINISH : S_DN_CHK;
      end
      S_DN_CHK: begin
        if (stat.left_in) begin
          cmd       = CMD_RD_KIDS;
          state_nxt = S_DN_CMP;
        end else begin
          cmd       = CMD_WRITE_MOV;
          state_nxt = S_FINISH;
        end
      end
      S_DN_CMP: begin
        case (stat.dn_dir)
          DN_LEFT: begin
            cmd       = CMD_DN_MOVE_L;
            state_nxt = S_DN_CHK;
          end
          DN_RIGHT: begin
            cmd       = CMD_DN_MOVE_R;
            state_nxt = S_DN_CHK;
          end
          default: begin
            cmd       = CMD_WRITE_MOV;
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd       = CMD_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* tb/binary_min_heap_queue_unit_tb.sv */
module binary_min_heap_queue_unit_tb;
  import bmhq_pkg::*;

  localparam int CAP          = DEF_CAPACITY;
  localparam int N_DIRECTED   = 24;
  localparam int N_RANDOM     = 1926;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT      = 120;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  typedef struct {
    logic             mode;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } heap_req_t;

  typedef struct {
    logic [ID_W-1:0]     popped_id;
    logic [KEY_W-1:0]    popped_key;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
  } heap_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  bmhq_in_if  in_ch();
  bmhq_out_if out_ch();

  binary_min_heap_queue_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow heap
  logic [ID_W-1:0]  heap_ids  [CAP];
  logic [KEY_W-1:0] heap_keys [CAP];
  int               heap_fill = 0;

  heap_req_t pending_reqs[$];
  heap_res_t expected_results[$];

  int reqs_queued   = 0;
  int reqs_accepted = 0;
  int results_seen  = 0;
  int error_cnt     = 0;
  int gen_count     = 0;
  int n_push        = 0;
  int n_pop         = 0;
  int n_full        = 0;
  int n_empty       = 0;
  int peak_fill     = 0;
  int stall_cycles  = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  heap_req_t drv_req;
  heap_res_t mon_exp;

  function automatic void swap_slots(int a, int b);
    logic [ID_W-1:0]  tid;
    logic [KEY_W-1:0] tkey;
    tid          = heap_ids[a];
    tkey         = heap_keys[a];
    heap_ids[a]  = heap_ids[b];
    heap_keys[a] = heap_keys[b];
    heap_ids[b]  = tid;
    heap_keys[b] = tkey;
  endfunction

  function automatic heap_res_t heap_apply(heap_req_t r);
    heap_res_t res;
    int        pos;
    int        parent;
    int        left;
    int        right;
    int        pick;
    res.popped_id  = '0;
    res.popped_key = '0;
    res.status     = ST_OK;
    if (r.mode == MODE_PUSH) begin
      if (heap_fill >= CAP) begin
        res.status = ST_FULL;
        n_full++;
      end else begin
        pos = heap_fill;
        heap_ids[pos]  = r.id;
        heap_keys[pos] = r.key;
        heap_fill++;
        n_push++;
        // equal keys never pass the parent
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_keys[pos] < heap_keys[parent]) begin
            swap_slots(pos, parent);
            pos = parent;
          end else begin
            break;
          end
        end
      end
    end else if (heap_fill == 0) begin
      res.status = ST_EMPTY;
      n_empty++;
    end else begin
      res.popped_id  = heap_ids[0];
      res.popped_key = heap_keys[0];
      heap_fill--;
      n_pop++;
      heap_ids[0]  = heap_ids[heap_fill];
      heap_keys[0] = heap_keys[heap_fill];
      pos = 0;
      forever begin
        left  = 2 * pos + 1;
        right = left + 1;
        if (left >= heap_fill) break;
        if (right < heap_fill) begin
          if (heap_keys[pos] <= heap_keys[left] && heap_keys[pos] <= heap_keys[right]) break;
          // tie between children goes right
          pick = (heap_keys[left] < heap_keys[right]) ? left : right;
        end else if (heap_keys[left] < heap_keys[pos]) begin
          pick = left;
        end else begin
          break;
        end
        swap_slots(pos, pick);
        pos = pick;
      end
    end
    if (heap_fill > peak_fill) peak_fill = heap_fill;
    res.entry_count = COUNT_W'(heap_fill);
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 3))
      0: k = KEY_W'($urandom);
      1: k = KEY_W'($urandom_range(0, 15));
      2: k = ($urandom_range(0, 1) != 0) ? KEY_MAX : '0;
      default: k = KEY_MAX - KEY_W'($urandom_range(0, 15));
    endcase
    return k;
  endfunction

  task automatic add_req(logic mode, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
    heap_req_t r;
    r.mode = mode;
    r.id   = id;
    r.key  = key;
    pending_reqs.push_back(r);
    reqs_queued++;
    if (mode == MODE_PUSH && gen_count < CAP) gen_count++;
    if (mode == MODE_POP && gen_count > 0) gen_count--;
  endtask

  task automatic add_random(logic mode);
    add_req(mode, ID_W'($urandom), rand_key());
  endtask

  function automatic int send_idle_pct();
    return (reqs_accepted < 650) ? 19 : (reqs_accepted < 1300) ? 61 : 0;
  endfunction

  function automatic int recv_idle_pct();
    return (reqs_accepted < 650) ? 61 : (reqs_accepted < 1300) ? 19 : 0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        drv_req.mode = in_ch.mode;
        drv_req.id   = in_ch.item_id;
        drv_req.key  = in_ch.item_key;
        expected_results.push_back(heap_apply(drv_req));
        reqs_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          drv_req = pending_reqs.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.mode     <= drv_req.mode;
          in_ch.item_id  <= drv_req.id;
          in_ch.item_key <= drv_req.key;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result-side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          error_cnt++;
          if (error_cnt <= MAX_REPORTS)
            $display("unexpected result: id %0d key %0d status %0d count %0d",
                     out_ch.popped_id, out_ch.popped_key, out_ch.status,
                     out_ch.entry_count);
        end else begin
          mon_exp = expected_results.pop_front();
          if (out_ch.popped_id !== mon_exp.popped_id ||
              out_ch.popped_key !== mon_exp.popped_key ||
              out_ch.status !== mon_exp.status ||
              out_ch.entry_count !== mon_exp.entry_count) begin
            error_cnt++;
            if (error_cnt <= MAX_REPORTS)
              $display("mismatch on result %0d: exp id %0d key %0d status %0d count %0d, got id %0d key %0d status %0d count %0d",
                       results_seen, mon_exp.popped_id, mon_exp.popped_key,
                       mon_exp.status, mon_exp.entry_count, out_ch.popped_id,
                       out_ch.popped_key, out_ch.status, out_ch.entry_count);
          end
        end
      end
      // one long hold-off so requests back up into the block
      if (!hold_done && reqs_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int seg;
    int len;
    int push_pct;
    bit first;

    in_ch.valid    = 1'b0;
    in_ch.mode     = MODE_PUSH;
    in_ch.item_id  = '0;
    in_ch.item_key = '0;
    out_ch.ready   = 1'b0;

    // directed: empty pop, key extremes, ties at push and at pop
    add_req(MODE_POP, 8'hFF, KEY_MAX);
    add_req(MODE_PUSH, 8'h00, KEY_MAX);
    add_req(MODE_PUSH, 8'hFF, '0);
    add_req(MODE_PUSH, 8'h5A, 31'd9);
    add_req(MODE_PUSH, 8'hA5, 31'd9);
    add_req(MODE_PUSH, 8'h3C, 31'd9);
    add_req(MODE_PUSH, 8'hC3, 31'd9);
    add_req(MODE_PUSH, 8'h01, '0);
    add_req(MODE_PUSH, 8'h80, KEY_MAX);
    repeat (8) add_req(MODE_POP, 8'h00, '0);
    add_req(MODE_POP, 8'hAA, 31'h2AAAAAAA);
    add_req(MODE_PUSH, 8'h7F, 31'd1);
    add_req(MODE_PUSH, 8'hFE, 31'd1);
    add_req(MODE_PUSH, 8'h55, 31'h55555555);
    add_req(MODE_POP, 8'h00, '0);
    add_req(MODE_POP, 8'h00, '0);
    add_req(MODE_POP, 8'h00, '0);

    // random: fill to full, drain to empty, mixed runs
    first = 1'b1;
    while (reqs_queued < N_DIRECTED + N_RANDOM) begin
      seg = first ? 0 : $urandom_range(0, 7);
      first = 1'b0;
      if (seg == 0) begin
        while (gen_count < CAP && reqs_queued < N_DIRECTED + N_RANDOM)
          add_random(MODE_PUSH);
        repeat ($urandom_range(1, 3)) add_random(MODE_PUSH);
      end else if (seg == 1) begin
        while (gen_count > 0 && reqs_queued < N_DIRECTED + N_RANDOM)
          add_random(MODE_POP);
        repeat ($urandom_range(1, 2)) add_random(MODE_POP);
      end else begin
        len = $urandom_range(20, 60);
        push_pct = $urandom_range(30, 80);
        repeat (len) begin
          if ($urandom_range(0, 99) < push_pct) add_random(MODE_PUSH);
          else add_random(MODE_POP);
        end
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (reqs_accepted < reqs_queued || expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_results.size() != 0) begin
      error_cnt++;
      $display("%0d results never arrived", expected_results.size());
    end

    $display("run covered %0d pushes, %0d pops, %0d pushes refused as full, %0d pops on empty",
             n_push, n_pop, n_full, n_empty);
    $display("deepest fill %0d of %0d entries, %0d results checked, %0d mismatches",
             peak_fill, CAP, results_seen, error_cnt);
    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
